[hdl/cbmv_pkg.sv]
// Shared types and constants for the column base majority vote block.
// No dependencies; imported by cbmv_tally and column_base_majority_vote.
package cbmv_pkg;

  localparam int unsigned TallyWidth = 11;
  localparam int unsigned NumBases   = 4;

  typedef logic [TallyWidth-1:0] tally_t;

  // Slot order is also the tie-break order.
  typedef enum logic [1:0] {
    SLOT_T = 2'd0,
    SLOT_C = 2'd1,
    SLOT_A = 2'd2,
    SLOT_G = 2'd3
  } base_slot_e;

  localparam logic [7:0] ChrUpperT = 8'h54;
  localparam logic [7:0] ChrUpperC = 8'h43;
  localparam logic [7:0] ChrUpperA = 8'h41;
  localparam logic [7:0] ChrUpperG = 8'h47;
  localparam logic [7:0] ChrLowerT = 8'h74;
  localparam logic [7:0] ChrLowerC = 8'h63;
  localparam logic [7:0] ChrLowerA = 8'h61;
  localparam logic [7:0] ChrLowerG = 8'h67;

  localparam tally_t TallyMax = {TallyWidth{1'b1}};

  // One input word.
  typedef struct packed {
    logic [7:0] base_char;
    logic       last_of_column;
    logic       last_position;
  } in_item_t;

  // Vote outcome of one column.
  typedef struct packed {
    logic [6:0] consensus_char;
    logic       no_votes;
  } vote_t;

  function automatic logic [6:0] slot_letter(base_slot_e slot);
    logic [6:0] letter;
    unique case (slot)
      SLOT_T: letter = ChrUpperT[6:0];
      SLOT_C: letter = ChrUpperC[6:0];
      SLOT_A: letter = ChrUpperA[6:0];
      SLOT_G: letter = ChrUpperG[6:0];
      default: letter = ChrUpperT[6:0];
    endcase
    return letter;
  endfunction

endpackage

[hdl/cbmv_if.sv]
// Valid/ready channel interfaces for the column base majority vote block.
// cbmv_in_if carries sequence characters, cbmv_out_if carries consensus words.
interface cbmv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_char;
  logic       last_of_column;
  logic       last_position;

  modport source (output valid, base_char, last_of_column, last_position, input ready);
  modport sink   (input valid, base_char, last_of_column, last_position, output ready);
endinterface

interface cbmv_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] consensus_char;
  logic       no_votes;
  logic       end_of_consensus;

  modport source (output valid, consensus_char, no_votes, end_of_consensus, input ready);
  modport sink   (input valid, consensus_char, no_votes, end_of_consensus, output ready);
endinterface

[hdl/cbmv_tally.sv]
// Four saturating base counters and the column majority vote.
// Depends on cbmv_pkg.
module cbmv_tally
  import cbmv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_item_t item_i,
  output vote_t    vote_o
);

  tally_t        tally_q [NumBases];
  tally_t        tally_d [NumBases];
  tally_t        tally_upd [NumBases];
  logic [NumBases-1:0] hit;
  base_slot_e    best;
  tally_t        best_cnt;

  always_comb begin
    hit = '0;
    unique case (item_i.base_char)
      ChrUpperT, ChrLowerT: hit[SLOT_T] = 1'b1;
      ChrUpperC, ChrLowerC: hit[SLOT_C] = 1'b1;
      ChrUpperA, ChrLowerA: hit[SLOT_A] = 1'b1;
      ChrUpperG, ChrLowerG: hit[SLOT_G] = 1'b1;
      default: hit = '0;
    endcase
  end

  always_comb begin
    for (int k = 0; k < NumBases; k++) begin
      if (hit[k] && tally_q[k] != TallyMax) begin
        tally_upd[k] = tally_q[k] + tally_t'(1);
      end else begin
        tally_upd[k] = tally_q[k];
      end
    end
  end

  // Strict greater-than keeps the earlier base on ties.
  always_comb begin
    best     = SLOT_T;
    best_cnt = tally_upd[SLOT_T];
    if (tally_upd[SLOT_C] > best_cnt) begin
      best     = SLOT_C;
      best_cnt = tally_upd[SLOT_C];
    end
    if (tally_upd[SLOT_A] > best_cnt) begin
      best     = SLOT_A;
      best_cnt = tally_upd[SLOT_A];
    end
    if (tally_upd[SLOT_G] > best_cnt) begin
      best     = SLOT_G;
      best_cnt = tally_upd[SLOT_G];
    end
  end

  assign vote_o.consensus_char = slot_letter(best);
  assign vote_o.no_votes       = (best_cnt == '0);

  always_comb begin
    for (int k = 0; k < NumBases; k++) begin
      if (!step_i) begin
        tally_d[k] = tally_q[k];
      end else if (item_i.last_of_column) begin
        tally_d[k] = '0;
      end else begin
        tally_d[k] = tally_upd[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumBases; k++) tally_q[k] <= '0;
    end else begin
      for (int k = 0; k < NumBases; k++) tally_q[k] <= tally_d[k];
    end
  end

  a_clear_after_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.last_of_column) |=>
      (tally_q[0] == '0 && tally_q[1] == '0 && tally_q[2] == '0 && tally_q[3] == '0))
    else $error("tally not cleared after column close");

  a_one_counter_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !item_i.last_of_column) |=>
      $countones({tally_q[0] != $past(tally_q[0]), tally_q[1] != $past(tally_q[1]),
                  tally_q[2] != $past(tally_q[2]), tally_q[3] != $past(tally_q[3])}) <= 1)
    else $error("more than one counter changed on one word");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(tally_q[0]) && $stable(tally_q[1]) &&
                 $stable(tally_q[2]) && $stable(tally_q[3])))
    else $error("counters moved without a word");

  a_empty_gives_t: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vote_o.no_votes |-> vote_o.consensus_char == ChrUpperT[6:0])
    else $error("empty column must vote T");

endmodule

[hdl/column_base_majority_vote.sv]
// Column base majority vote, top level: input register, tally/vote, result register.
// Depends on cbmv_pkg, cbmv_in_if, cbmv_out_if and cbmv_tally.
//
// Usage: stream an alignment column by column on in_i, one sequence character per
// word, with last_of_column high on the column's last character and last_position
// high on that character when the column is the final one. Upper and lower case
// T, C, A, G are tallied in 11-bit saturating counters; any other code is ignored.
// Each closing word yields one word on out_o: the most frequent base (ties go to
// T, then C, then A, then G), no_votes when nothing was tallied (base reads T),
// and end_of_consensus copied from last_position. Counters clear after each vote.
// Throughput: one character per cycle, sustained unless a closing character waits
// for the result register. A closing character passes the input register, then the
// result register that the counter update and four-way compare feed, to out_o.
// Reset clears the counters and both valid flags; no word is pending afterwards.
// When out_o stalls, characters that do not close a column keep flowing into the
// counters; a closing character waits in the input register until the result
// register frees, and in_i.ready drops only then.
module column_base_majority_vote
  import cbmv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  cbmv_in_if.sink     in_i,
  cbmv_out_if.source  out_o
);

  logic     s1_valid_q, s1_valid_d;
  in_item_t s1_item_q;
  logic     s1_go;
  logic     out_free;
  logic     out_load;
  logic     out_valid_q, out_valid_d;
  vote_t    vote;
  vote_t    out_vote_q;
  logic     out_end_q;

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_go    = s1_valid_q && (!s1_item_q.last_of_column || out_free);
  assign out_load = s1_go && s1_item_q.last_of_column;
  assign in_i.ready = !s1_valid_q || s1_go;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_i.ready) begin
      s1_valid_d = in_i.valid;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_item_q.base_char      <= in_i.base_char;
      s1_item_q.last_of_column <= in_i.last_of_column;
      s1_item_q.last_position  <= in_i.last_position;
    end
    if (out_load) begin
      out_vote_q <= vote;
      out_end_q  <= s1_item_q.last_position;
    end
  end

  cbmv_tally u_tally (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_go),
    .item_i (s1_item_q),
    .vote_o (vote)
  );

  assign out_o.valid            = out_valid_q;
  assign out_o.consensus_char   = out_vote_q.consensus_char;
  assign out_o.no_votes         = out_vote_q.no_votes;
  assign out_o.end_of_consensus = out_end_q;

  a_close_makes_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_o.valid)
    else $error("closing word did not produce a result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !out_load)
    else $error("pending result overwritten");

  a_open_never_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_item_q.last_of_column) |-> in_i.ready)
    else $error("non-closing word stalled the input");

endmodule
